### rtl/vfc_pkg.sv
// ============================================================================
// vfc_pkg: shared types, constants and table builder for the frustum corners
// Holds the register indexes, the sequencer states of the setup unit, the
// result bundle it hands to the corner pipeline and the sine table function.
// ============================================================================
`default_nettype none

package vfc_pkg;

    localparam int TRIG_TABLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF       = 16;

    localparam int DIST_W  = 32;
    localparam int COORD_W = 32;
    localparam int HGT_W   = 45;
    localparam int WID_W   = 53;
    localparam int SUM_W   = 56;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [14:0] FOV_RESET    = 15'd8192;
    localparam logic [31:0] NEAR_RESET   = 32'd6554;
    localparam logic [31:0] FAR_RESET    = 32'd6553600;
    localparam logic [15:0] ASPECT_RESET = 16'd455;

    typedef enum logic [1:0] {
        CFG_FOV    = 2'd0,
        CFG_NEAR   = 2'd1,
        CFG_FAR    = 2'd2,
        CFG_ASPECT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CS_LOAD,
        CS_DIV,
        CS_H0,
        CS_H1,
        CS_W0,
        CS_W1,
        CS_IDLE
    } t_cfg_state;

    typedef struct packed {
        logic              busy;
        logic [DIST_W-1:0] dist_near;
        logic [DIST_W-1:0] dist_far;
        logic [HGT_W-1:0]  hgt_near;
        logic [HGT_W-1:0]  hgt_far;
        logic [WID_W-1:0]  wid_near;
        logic [WID_W-1:0]  wid_far;
    } t_cfg_res;

    // One quarter-wave sine entry, evaluated at elaboration only.
    function automatic logic [31:0] sine_entry(input int k, input int tb, input int fb);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        int                 qs;
        qs   = 1 << (tb - 2);
        x    = (64'(k) * HALF_PI_Q30 + 64'(qs >> 1)) >> (tb - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 8; n++) begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        rnd = (sum + (64'sd1 <<< (29 - fb))) >>> (30 - fb);
        if (k == 0) rnd = 0;
        if (k == qs) rnd = 64'sd1 <<< fb;
        return rnd[31:0];
    endfunction

endpackage

`default_nettype wire

### rtl/vfc_sincos.sv
// ============================================================================
// vfc_sincos: table sine and cosine of one angle step
// Quarter-wave constant table with quadrant folding.
// ============================================================================
`default_nettype none

module vfc_sincos #(
    parameter int TRIG_TABLE_BITS = vfc_pkg::TRIG_TABLE_BITS_DEF,
    parameter int FRAC_BITS       = vfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic [TRIG_TABLE_BITS-1:0] i_idx,
    output logic signed [FRAC_BITS+1:0]     o_sin,
    output logic signed [FRAC_BITS+1:0]     o_cos
);

    localparam int T  = TRIG_TABLE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int QS = 1 << (T - 2);

    logic [F:0] tab [QS+1];

    for (genvar k = 0; k <= QS; k++) begin : g_tab
        assign tab[k] = (F+1)'(vfc_pkg::sine_entry(k, T, F));
    end

    logic [T-1:0] cos_idx;
    logic [F:0]   sin_mag;
    logic [F:0]   cos_mag;

    assign cos_idx = i_idx + T'(QS);

    always_comb begin
        if (i_idx[T-2]) begin
            sin_mag = tab[(T-1)'(QS) - (T-1)'(i_idx[T-3:0])];
        end else begin
            sin_mag = tab[(T-1)'(i_idx[T-3:0])];
        end
        if (cos_idx[T-2]) begin
            cos_mag = tab[(T-1)'(QS) - (T-1)'(cos_idx[T-3:0])];
        end else begin
            cos_mag = tab[(T-1)'(cos_idx[T-3:0])];
        end
        o_sin = i_idx[T-1]   ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        o_cos = cos_idx[T-1] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    end

endmodule

`default_nettype wire

### rtl/vfc_cfg_calc.sv
// ============================================================================
// vfc_cfg_calc: configuration registers and plane size setup unit
// Holds the four registers and, after reset or any write, derives the
// half fov tangent with a bit-serial divider and the plane half sizes with
// a shift-add multiplier.
// ============================================================================
`default_nettype none

module vfc_cfg_calc #(
    parameter int TRIG_TABLE_BITS = vfc_pkg::TRIG_TABLE_BITS_DEF,
    parameter int FRAC_BITS       = vfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    output vfc_pkg::t_cfg_res      o_res
);

    localparam int T       = TRIG_TABLE_BITS;
    localparam int F       = FRAC_BITS;
    localparam int NW      = 2 * F + 2;
    localparam int MPW     = F + 13;
    localparam int MCW     = vfc_pkg::HGT_W;
    localparam int AW      = MCW + MPW + 1;
    localparam int QXW     = NW + MPW;
    localparam int CNT_MAX = (NW > MPW) ? NW : MPW;
    localparam int CW      = $clog2(CNT_MAX + 1);

    logic [14:0] r_fov;
    logic [31:0] r_near;
    logic [31:0] r_far;
    logic [15:0] r_aspect;

    vfc_pkg::t_cfg_state r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [F:0]     r_rem, n_rem;
    logic [NW-1:0]  r_quo, n_quo;
    logic [MCW-1:0] r_mc, n_mc;
    logic [MPW-1:0] r_mp, n_mp;
    logic [AW-1:0]  r_acc, n_acc;
    logic [MPW-1:0] r_tan, n_tan;
    logic [vfc_pkg::HGT_W-1:0] r_hgt0, n_hgt0, r_hgt1, n_hgt1;
    logic [vfc_pkg::WID_W-1:0] r_wid0, n_wid0, r_wid1, n_wid1;

    logic signed [F+1:0] st;
    logic signed [F+1:0] ct;
    logic [F:0]          ct_c;
    logic [NW-1:0]       num;
    logic [F+1:0]        rem_sh;
    logic                ge;
    logic [F:0]          rem_nx;
    logic [NW-1:0]       quo_nx;
    logic [MPW-1:0]      tan_cap;
    logic [AW-1:0]       acc_sum;
    logic [AW-1:0]       acc_nx;
    logic [AW-1:0]       rnd_f;
    logic [AW-1:0]       rnd_8;
    logic                last;

    vfc_sincos #(.TRIG_TABLE_BITS(T), .FRAC_BITS(F)) u_half_fov (
        .i_idx ({2'b00, r_fov[14:17-T]}),
        .o_sin (st),
        .o_cos (ct)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov    <= vfc_pkg::FOV_RESET;
            r_near   <= vfc_pkg::NEAR_RESET;
            r_far    <= vfc_pkg::FAR_RESET;
            r_aspect <= vfc_pkg::ASPECT_RESET;
        end else if (i_cfg_we) begin
            case (vfc_pkg::t_cfg_idx'(i_cfg_index))
                vfc_pkg::CFG_FOV:    r_fov    <= i_cfg_data[14:0];
                vfc_pkg::CFG_NEAR:   r_near   <= i_cfg_data;
                vfc_pkg::CFG_FAR:    r_far    <= i_cfg_data;
                vfc_pkg::CFG_ASPECT: r_aspect <= i_cfg_data[15:0];
                default:             r_fov    <= r_fov;
            endcase
        end
    end

    // Divider and multiplier datapath steps.
    always_comb begin
        ct_c    = (ct[F:0] == '0) ? (F+1)'(1) : ct[F:0];
        num     = NW'({st[F:0], {F{1'b0}}}) + NW'(ct_c >> 1);
        rem_sh  = {r_rem, r_quo[NW-1]};
        ge      = rem_sh >= (F+2)'(ct_c);
        rem_nx  = (F+1)'(ge ? rem_sh - (F+2)'(ct_c) : rem_sh);
        quo_nx  = {r_quo[NW-2:0], ge};
        if (QXW'(quo_nx) > (QXW'(1) << (F + 12))) begin
            tan_cap = MPW'(1) << (F + 12);
        end else begin
            tan_cap = MPW'(quo_nx);
        end
        acc_sum = r_acc + (r_mp[0] ? {1'b0, r_mc, {MPW{1'b0}}} : AW'(0));
        acc_nx  = acc_sum >> 1;
        rnd_f   = (acc_nx + (AW'(1) << (F - 1))) >> F;
        rnd_8   = (acc_nx + AW'(128)) >> 8;
        last    = (r_cnt == CW'(1));
    end

    // Setup sequencer: tangent, then near and far half heights, then widths.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_mc    = r_mc;
        n_mp    = r_mp;
        n_acc   = r_acc;
        n_tan   = r_tan;
        n_hgt0  = r_hgt0;
        n_hgt1  = r_hgt1;
        n_wid0  = r_wid0;
        n_wid1  = r_wid1;
        if (r_state == vfc_pkg::CS_H0 || r_state == vfc_pkg::CS_H1 ||
            r_state == vfc_pkg::CS_W0 || r_state == vfc_pkg::CS_W1) begin
            n_acc = acc_nx;
            n_mp  = r_mp >> 1;
            n_cnt = r_cnt - CW'(1);
        end
        case (r_state)
            vfc_pkg::CS_LOAD: begin
                n_rem   = '0;
                n_quo   = num;
                n_cnt   = CW'(NW);
                n_state = vfc_pkg::CS_DIV;
            end
            vfc_pkg::CS_DIV: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_cnt = r_cnt - CW'(1);
                if (last) begin
                    n_tan   = tan_cap;
                    n_mc    = MCW'(r_near);
                    n_mp    = tan_cap;
                    n_acc   = '0;
                    n_cnt   = CW'(MPW);
                    n_state = vfc_pkg::CS_H0;
                end
            end
            vfc_pkg::CS_H0: begin
                if (last) begin
                    n_hgt0  = rnd_f[vfc_pkg::HGT_W-1:0];
                    n_mc    = MCW'(r_far);
                    n_mp    = r_tan;
                    n_acc   = '0;
                    n_cnt   = CW'(MPW);
                    n_state = vfc_pkg::CS_H1;
                end
            end
            vfc_pkg::CS_H1: begin
                if (last) begin
                    n_hgt1  = rnd_f[vfc_pkg::HGT_W-1:0];
                    n_mc    = r_hgt0;
                    n_mp    = MPW'(r_aspect);
                    n_acc   = '0;
                    n_cnt   = CW'(MPW);
                    n_state = vfc_pkg::CS_W0;
                end
            end
            vfc_pkg::CS_W0: begin
                if (last) begin
                    n_wid0  = rnd_8[vfc_pkg::WID_W-1:0];
                    n_mc    = r_hgt1;
                    n_mp    = MPW'(r_aspect);
                    n_acc   = '0;
                    n_cnt   = CW'(MPW);
                    n_state = vfc_pkg::CS_W1;
                end
            end
            vfc_pkg::CS_W1: begin
                if (last) begin
                    n_wid1  = rnd_8[vfc_pkg::WID_W-1:0];
                    n_state = vfc_pkg::CS_IDLE;
                end
            end
            vfc_pkg::CS_IDLE: begin
                n_cnt = r_cnt;
            end
            default: begin
                n_state = vfc_pkg::CS_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_state = vfc_pkg::CS_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfc_pkg::CS_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_acc  <= n_acc;
        r_tan  <= n_tan;
        r_hgt0 <= n_hgt0;
        r_hgt1 <= n_hgt1;
        r_wid0 <= n_wid0;
        r_wid1 <= n_wid1;
    end

    always_comb begin
        o_res.busy      = (r_state != vfc_pkg::CS_IDLE);
        o_res.dist_near = r_near;
        o_res.dist_far  = r_far;
        o_res.hgt_near  = r_hgt0;
        o_res.hgt_far   = r_hgt1;
        o_res.wid_near  = r_wid0;
        o_res.wid_far   = r_wid1;
    end

endmodule

`default_nettype wire

### rtl/vfc_corner_pipe.sv
// ============================================================================
// vfc_corner_pipe: per-corner arithmetic pipeline
// Operand select, split products, rounding, signed sum and saturation, one
// corner beat per cycle unless the output stalls, with an output register.
// ============================================================================
`default_nettype none

module vfc_corner_pipe #(
    parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  vfc_pkg::t_cfg_res              i_cfg,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [2:0]                i_k,
    input  wire logic                      i_degen,
    input  wire logic signed [31:0]        i_pos   [3],
    input  wire logic signed [FRAC_BITS+1:0] i_front [3],
    input  wire logic signed [FRAC_BITS+1:0] i_up    [3],
    input  wire logic signed [FRAC_BITS+1:0] i_right [3],
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [2:0]                     o_corner_index,
    output logic signed [31:0]             o_corner_x,
    output logic signed [31:0]             o_corner_y,
    output logic signed [31:0]             o_corner_z,
    output logic                           o_degenerate,
    output logic                           o_last_corner
);

    localparam int F  = FRAC_BITS;
    localparam int MW = F + 1;
    localparam int SW = vfc_pkg::SUM_W;
    localparam int HW = vfc_pkg::HGT_W;
    localparam int WW = vfc_pkg::WID_W;
    localparam int PF = MW + 32;
    localparam int PU = MW + HW;
    localparam int PW = MW + WW;

    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic en1, en2, en3, en4, en_o;

    assign en_o    = !r_vo || i_ready;
    assign en4     = !r_v4 || en_o;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vo;

    // Stage 1: magnitudes, term signs and plane operands.
    logic [2:0]          r1_k, r2_k, r3_k, r4_k;
    logic                r1_dg, r2_dg, r3_dg, r4_dg;
    logic signed [31:0]  r1_pos [3];
    logic signed [31:0]  r2_pos [3];
    logic signed [31:0]  r3_pos [3];
    logic [MW-1:0]       r1_fm [3];
    logic [MW-1:0]       r1_um [3];
    logic [MW-1:0]       r1_rm [3];
    logic [2:0]          r1_fs, r1_us, r1_rs, r2_fs, r2_us, r2_rs, r3_fs, r3_us, r3_rs;
    logic [31:0]         r1_d;
    logic [HW-1:0]       r1_h;
    logic [WW-1:0]       r1_w;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_k  <= i_k;
            r1_dg <= i_degen;
            r1_d  <= i_k[2] ? i_cfg.dist_far : i_cfg.dist_near;
            r1_h  <= i_k[2] ? i_cfg.hgt_far  : i_cfg.hgt_near;
            r1_w  <= i_k[2] ? i_cfg.wid_far  : i_cfg.wid_near;
            for (int a = 0; a < 3; a++) begin
                r1_pos[a] <= i_pos[a];
                r1_fm[a]  <= MW'(i_front[a][F+1] ? -i_front[a] : i_front[a]);
                r1_um[a]  <= MW'(i_up[a][F+1]    ? -i_up[a]    : i_up[a]);
                r1_rm[a]  <= MW'(i_right[a][F+1] ? -i_right[a] : i_right[a]);
                r1_fs[a]  <= i_front[a][F+1];
                // Bottom corners flip up, left corners flip right.
                r1_us[a]  <= i_up[a][F+1] ^ i_k[1];
                r1_rs[a]  <= i_right[a][F+1] ^ ~i_k[0];
            end
        end
    end

    // Stage 2: products, wide operands split at bit 32.
    logic [PF-1:0]        r2_pf    [3];
    logic [MW+31:0]       r2_pu_lo [3];
    logic [MW+HW-33:0]    r2_pu_hi [3];
    logic [MW+31:0]       r2_pw_lo [3];
    logic [MW+WW-33:0]    r2_pw_hi [3];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_k  <= r1_k;
            r2_dg <= r1_dg;
            r2_fs <= r1_fs;
            r2_us <= r1_us;
            r2_rs <= r1_rs;
            for (int a = 0; a < 3; a++) begin
                r2_pos[a]   <= r1_pos[a];
                r2_pf[a]    <= PF'(r1_fm[a]) * PF'(r1_d);
                r2_pu_lo[a] <= (MW+32)'(r1_um[a]) * (MW+32)'(r1_h[31:0]);
                r2_pu_hi[a] <= (MW+HW-32)'(r1_um[a]) * (MW+HW-32)'(r1_h[HW-1:32]);
                r2_pw_lo[a] <= (MW+32)'(r1_rm[a]) * (MW+32)'(r1_w[31:0]);
                r2_pw_hi[a] <= (MW+WW-32)'(r1_rm[a]) * (MW+WW-32)'(r1_w[WW-1:32]);
            end
        end
    end

    // Stage 3: join the halves and round to nearest, half away from zero.
    logic [32:0]   r3_f [3];
    logic [HW-1:0] r3_u [3];
    logic [WW-1:0] r3_w [3];
    logic [PF-1:0] tf [3];
    logic [PU-1:0] tu [3];
    logic [PW-1:0] tw [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            tf[a] = r2_pf[a] + (PF'(1) << (F - 1));
            tu[a] = (PU'(r2_pu_hi[a]) << 32) + PU'(r2_pu_lo[a]) + (PU'(1) << (F - 1));
            tw[a] = (PW'(r2_pw_hi[a]) << 32) + PW'(r2_pw_lo[a]) + (PW'(1) << (F - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_k  <= r2_k;
            r3_dg <= r2_dg;
            r3_fs <= r2_fs;
            r3_us <= r2_us;
            r3_rs <= r2_rs;
            for (int a = 0; a < 3; a++) begin
                r3_pos[a] <= r2_pos[a];
                r3_f[a]   <= tf[a][F+32:F];
                r3_u[a]   <= tu[a][F+HW-1:F];
                r3_w[a]   <= tw[a][F+WW-1:F];
            end
        end
    end

    // Stage 4: signed sum of position and the three terms.
    logic signed [SW-1:0] sum [3];
    logic signed [SW-1:0] r4_sum [3];

    always_comb begin
        logic signed [SW-1:0] vf;
        logic signed [SW-1:0] vu;
        logic signed [SW-1:0] vw;
        for (int a = 0; a < 3; a++) begin
            vf = $signed(SW'(r3_f[a]));
            vu = $signed(SW'(r3_u[a]));
            vw = $signed(SW'(r3_w[a]));
            if (r3_fs[a]) vf = -vf;
            if (r3_us[a]) vu = -vu;
            if (r3_rs[a]) vw = -vw;
            sum[a] = SW'(r3_pos[a]) + vf + vu + vw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_k  <= r3_k;
            r4_dg <= r3_dg;
            for (int a = 0; a < 3; a++) begin
                r4_sum[a] <= sum[a];
            end
        end
    end

    // Output register with saturation to signed Q16.16.
    logic signed [31:0] sat [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r4_sum[a] > $signed(SW'(32'sh7FFF_FFFF))) begin
                sat[a] = 32'sh7FFF_FFFF;
            end else if (r4_sum[a] < -$signed(SW'(33'sh0_8000_0000))) begin
                sat[a] = 32'sh8000_0000;
            end else begin
                sat[a] = r4_sum[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            o_corner_index <= r4_k;
            o_corner_x     <= sat[0];
            o_corner_y     <= sat[1];
            o_corner_z     <= sat[2];
            o_degenerate   <= r4_dg;
            o_last_corner  <= (r4_k == 3'd7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)  r_v1 <= i_valid;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en4)  r_v4 <= r_v3;
            if (en_o) r_vo <= r_v4;
        end
    end

endmodule

`default_nettype wire

### rtl/view_frustum_corners_unit.sv
// ============================================================================
// view_frustum_corners_unit: perspective view frustum corners, fixed point
// Takes a camera position with pitch and yaw and returns the eight frustum
// corners, near TL, TR, BL, BR then far TL, TR, BL, BR, as Q16.16 beats.
// ============================================================================
//
//  Channel   Handshake            Beat contents
//  --------  -------------------  ---------------------------------------
//  camera    i_valid / o_ready    pos x/y/z, pitch angle, yaw angle
//  corners   o_valid / i_ready    corner index, x/y/z, degenerate, last
//  config    i_cfg_we             register index, write data
//
// Each camera beat yields eight corner beats, one per cycle while the corner
// side does not stall, and the corner issue stage, which walks the eight
// corners, sets how often a camera beat can be taken. After reset and after
// every config write the setup unit runs the tangent divide and the plane
// size multiplies, and o_ready stays low meanwhile. A stall on the corner
// side freezes the whole pipeline in place; nothing is dropped or repeated.
// ============================================================================
`default_nettype none

module view_frustum_corners_unit #(
    parameter int TRIG_TABLE_BITS = vfc_pkg::TRIG_TABLE_BITS_DEF,
    parameter int FRAC_BITS       = vfc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic [15:0]        i_pitch_angle,
    input  wire logic [15:0]        i_yaw_angle,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_corner_index,
    output logic signed [31:0]      o_corner_x,
    output logic signed [31:0]      o_corner_y,
    output logic signed [31:0]      o_corner_z,
    output logic                    o_degenerate,
    output logic                    o_last_corner
);

    localparam int T  = TRIG_TABLE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int MW = F + 1;
    localparam int CS = F + 2;

    // Setup unit: registers and the derived plane half sizes.
    vfc_pkg::t_cfg_res cfg;

    vfc_cfg_calc #(.TRIG_TABLE_BITS(T), .FRAC_BITS(F)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (cfg)
    );

    // Table lookups straight from the camera beat.
    logic signed [CS-1:0] sp, cp, sy, cy;

    vfc_sincos #(.TRIG_TABLE_BITS(T), .FRAC_BITS(F)) u_pitch (
        .i_idx (i_pitch_angle[15:16-T]),
        .o_sin (sp),
        .o_cos (cp)
    );

    vfc_sincos #(.TRIG_TABLE_BITS(T), .FRAC_BITS(F)) u_yaw (
        .i_idx (i_yaw_angle[15:16-T]),
        .o_sin (sy),
        .o_cos (cy)
    );

    // Handshake chain: A (lookup), B (axes), Q (corner issue).
    logic r_a_valid, r_b_valid, r_q_valid;
    logic [2:0] r_q_k;
    logic cp_ready;
    logic q_free, en_b, en_a, accept;

    assign q_free  = !r_q_valid || (r_q_k == 3'd7 && cp_ready);
    assign en_b    = !r_b_valid || q_free;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a && !cfg.busy;
    assign accept  = i_valid && o_ready;

    // Stage A registers the position and the four table values.
    logic signed [31:0]   r_a_pos [3];
    logic signed [CS-1:0] r_a_sp, r_a_cp, r_a_sy, r_a_cy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pos[0] <= i_pos_x;
            r_a_pos[1] <= i_pos_y;
            r_a_pos[2] <= i_pos_z;
            r_a_sp     <= sp;
            r_a_cp     <= cp;
            r_a_sy     <= sy;
            r_a_cy     <= cy;
        end
    end

    // Rounded Q product of two table values; magnitudes never exceed one.
    function automatic logic signed [CS-1:0] qmul(input logic signed [CS-1:0] a,
                                                  input logic signed [CS-1:0] b);
        logic [MW-1:0]   ma;
        logic [MW-1:0]   mb;
        logic [2*MW-1:0] p;
        logic [MW-1:0]   m;
        ma = MW'(a[CS-1] ? -a : a);
        mb = MW'(b[CS-1] ? -b : b);
        p  = (2*MW)'(ma) * (2*MW)'(mb) + ((2*MW)'(1) << (F - 1));
        m  = p[F+MW-1:F];
        return (a[CS-1] ^ b[CS-1]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // Stage B forms the camera axes. The sign of cos(pitch) keeps right
    // and up consistent without a square root; a zero cosine counts as
    // positive and is flagged as degenerate.
    logic signed [31:0]   r_b_pos   [3];
    logic signed [CS-1:0] r_b_front [3];
    logic signed [CS-1:0] r_b_up    [3];
    logic signed [CS-1:0] r_b_right [3];
    logic                 r_b_dg;
    logic signed [CS-1:0] p_sycp, p_cycp, p_sysp, p_cysp;
    logic                 cneg;

    always_comb begin
        p_sycp = qmul(r_a_sy, r_a_cp);
        p_cycp = qmul(r_a_cy, r_a_cp);
        p_sysp = qmul(r_a_sy, r_a_sp);
        p_cysp = qmul(r_a_cy, r_a_sp);
        cneg   = r_a_cp[CS-1];
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_pos      <= r_a_pos;
            r_b_front[0] <= -p_sycp;
            r_b_front[1] <= r_a_sp;
            r_b_front[2] <= -p_cycp;
            r_b_right[0] <= cneg ? -r_a_cy : r_a_cy;
            r_b_right[1] <= '0;
            r_b_right[2] <= cneg ? r_a_sy : -r_a_sy;
            r_b_up[0]    <= cneg ? -p_sysp : p_sysp;
            r_b_up[1]    <= cneg ? -r_a_cp : r_a_cp;
            r_b_up[2]    <= cneg ? -p_cysp : p_cysp;
            r_b_dg       <= (r_a_cp == '0);
        end
    end

    // Stage Q holds one camera beat and issues its eight corners in turn.
    logic signed [31:0]   r_q_pos   [3];
    logic signed [CS-1:0] r_q_front [3];
    logic signed [CS-1:0] r_q_up    [3];
    logic signed [CS-1:0] r_q_right [3];
    logic                 r_q_dg;

    always_ff @(posedge i_clk) begin
        if (q_free) begin
            r_q_pos   <= r_b_pos;
            r_q_front <= r_b_front;
            r_q_up    <= r_b_up;
            r_q_right <= r_b_right;
            r_q_dg    <= r_b_dg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_q_k     <= '0;
        end else begin
            if (en_a) r_a_valid <= accept;
            if (en_b) r_b_valid <= r_a_valid;
            if (q_free) begin
                r_q_valid <= r_b_valid;
                r_q_k     <= '0;
            end else if (r_q_valid && cp_ready) begin
                r_q_k <= r_q_k + 3'd1;
            end
        end
    end

    vfc_corner_pipe #(.FRAC_BITS(F)) u_corner (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (r_q_valid),
        .o_ready        (cp_ready),
        .i_k            (r_q_k),
        .i_degen        (r_q_dg),
        .i_pos          (r_q_pos),
        .i_front        (r_q_front),
        .i_up           (r_q_up),
        .i_right        (r_q_right),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_corner_index (o_corner_index),
        .o_corner_x     (o_corner_x),
        .o_corner_y     (o_corner_y),
        .o_corner_z     (o_corner_z),
        .o_degenerate   (o_degenerate),
        .o_last_corner  (o_last_corner)
    );

endmodule

`default_nettype wire

### rtl/vfc_checker.sv
// ============================================================================
// vfc_checker: port-level checks for the frustum corners unit
// Watches the corner channel for ordering and framing of the corner beats.
// ============================================================================
`default_nettype none

module vfc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [2:0]         o_corner_index,
    input wire logic signed [31:0] o_corner_x,
    input wire logic               o_degenerate,
    input wire logic               o_last_corner
);

    // A stalled corner beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_corner_index) && $stable(o_corner_x))
        else $error("stalled corner beat changed");

    // The last flag marks exactly the eighth corner.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_corner == (o_corner_index == 3'd7)))
        else $error("last flag out of step with corner index");

    // Corners of one camera beat follow each other with no gap.
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_corner |=>
            o_valid && (o_corner_index == 3'($past(o_corner_index) + 3'd1))
            && $stable(o_degenerate))
        else $error("corner run broken");

    // Nothing is shown right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("corner beat right after reset");

endmodule

bind view_frustum_corners_unit vfc_checker u_vfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_corner_index (o_corner_index),
    .o_corner_x     (o_corner_x),
    .o_degenerate   (o_degenerate),
    .o_last_corner  (o_last_corner)
);

`default_nettype wire

### sim/view_frustum_corners_unit_tb.sv
// ============================================================================
// view_frustum_corners_unit_tb: self-checking bench for the frustum corners
// Camera beats are fed through a valid/ready driver, and every corner beat
// is checked against a fixed-point model of the camera axes, tangent and
// plane sizes. Register settings are changed between phases while idle.
// ============================================================================
`default_nettype none

module view_frustum_corners_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QSTEPS   = 256;
    localparam logic [63:0] MAG_CAP  = 64'd1 << 60;
    localparam int          WD_LIMIT = 5000;

    typedef enum logic [1:0] {
        OP_CAMERA,
        OP_CFG,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind          kind;
        vfc_pkg::t_cfg_idx reg_idx;
        logic [31:0]       reg_data;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
        logic [15:0]       pitch;
        logic [15:0]       yaw;
    } t_op;

    typedef struct {
        logic [2:0]  index;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic        degen;
        logic        last;
    } t_corner;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic [15:0] i_pitch_angle = '0;
    logic [15:0] i_yaw_angle = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [2:0] o_corner_index;
    logic signed [31:0] o_corner_x;
    logic signed [31:0] o_corner_y;
    logic signed [31:0] o_corner_z;
    logic o_degenerate;
    logic o_last_corner;

    view_frustum_corners_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_pitch_angle (i_pitch_angle),
        .i_yaw_angle   (i_yaw_angle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_corner_index(o_corner_index),
        .o_corner_x    (o_corner_x),
        .o_corner_y    (o_corner_y),
        .o_corner_z    (o_corner_z),
        .o_degenerate  (o_degenerate),
        .o_last_corner (o_last_corner)
    );

    // Model copy of the registers, the quarter-wave table and the queues.
    logic [14:0] fov_q = vfc_pkg::FOV_RESET;
    logic [31:0] near_q = vfc_pkg::NEAR_RESET;
    logic [31:0] far_q = vfc_pkg::FAR_RESET;
    logic [15:0] aspect_q = vfc_pkg::ASPECT_RESET;
    longint      sine_quadrant [0:QSTEPS];

    t_op     camera_ops [$];
    t_corner corners_due [$];

    logic camera_taken = 1'b0;
    logic calm = 1'b0;       // set during the stretch with no idling
    int   quiet_cycles = 0;
    int   stall_cycles = 0;
    int   mismatches = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Quarter-wave sine from a truncating nine-term Taylor series in Q30,
    // rounded half up into Q16 with the end points forced exact.
    function automatic void build_sine_quadrant();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        for (int k = 0; k <= QSTEPS; k++) begin
            x = (64'(k) * vfc_pkg::HALF_PI_Q30 + 64'(QSTEPS / 2)) >> 8;
            x2 = (x * x) >> 30;
            term = x;
            acc = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
            sine_quadrant[k] = (acc + (64'sd1 <<< 13)) >>> 14;
        end
        sine_quadrant[0] = 0;
        sine_quadrant[QSTEPS] = 64'sd1 <<< 16;
    endfunction

    function automatic longint sine_of(logic [9:0] step);
        longint v;
        v = step[8] ? sine_quadrant[QSTEPS - int'(step[7:0])] : sine_quadrant[step[7:0]];
        return step[9] ? -v : v;
    endfunction

    function automatic longint cosine_of(logic [9:0] step);
        return sine_of(step + 10'd256);
    endfunction

    // Unsigned product shifted right by sh with half-up rounding, capped.
    function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        if ((p >> (64 + sh)) != 0) return MAG_CAP;
        r = 64'(p >> sh);
        return (r > MAG_CAP) ? MAG_CAP : r;
    endfunction

    // Signed version: the magnitude is rounded, so halves go away from zero.
    function automatic longint smul_round(longint a, longint b, int sh);
        logic [63:0] ua;
        logic [63:0] ub;
        longint      r;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        r = longint'(mul_round(ua, ub, sh));
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [31:0] clamp_q16(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Expected eight corners of one camera beat under the current settings.
    function automatic void predict_corners(t_op cam);
        longint      pos [3];
        longint      front [3];
        longint      right [3];
        longint      up [3];
        longint      sp, cp, sy, cy, st, ct, tanv, sgn, v, vs, hs;
        logic [63:0] plane_dist [2];
        logic [63:0] hgt [2];
        logic [63:0] wid [2];
        logic [9:0]  half_step;
        t_corner     c;
        pos[0] = longint'($signed(cam.px));
        pos[1] = longint'($signed(cam.py));
        pos[2] = longint'($signed(cam.pz));
        sp = sine_of(cam.pitch[15:6]);
        cp = cosine_of(cam.pitch[15:6]);
        sy = sine_of(cam.yaw[15:6]);
        cy = cosine_of(cam.yaw[15:6]);
        sgn = (cp < 0) ? -1 : 1;
        front[0] = -smul_round(sy, cp, 16);
        front[1] = sp;
        front[2] = -smul_round(cy, cp, 16);
        right[0] = sgn * cy;
        right[1] = 0;
        right[2] = -sgn * sy;
        up[0] = sgn * smul_round(sy, sp, 16);
        up[1] = sgn * cp;
        up[2] = sgn * smul_round(cy, sp, 16);

        half_step = 10'(fov_q >> 7);
        st = sine_of(half_step);
        ct = cosine_of(half_step);
        if (ct < 1) ct = 1;
        tanv = ((st <<< 16) + (ct >>> 1)) / ct;
        if (tanv > (64'sd1 <<< 28)) tanv = 64'sd1 <<< 28;

        plane_dist[0] = 64'(near_q);
        plane_dist[1] = 64'(far_q);
        for (int i = 0; i < 2; i++) begin
            hgt[i] = mul_round(plane_dist[i], 64'(tanv), 16);
            wid[i] = mul_round(hgt[i], 64'(aspect_q), 8);
        end

        for (int k = 0; k < 8; k++) begin
            vs = (k & 2) ? -1 : 1;
            hs = (k & 1) ? 1 : -1;
            c.index = 3'(k);
            c.degen = (cp == 0);
            c.last = (k == 7);
            for (int i = 0; i < 3; i++) begin
                v = pos[i] + smul_round(front[i], longint'(plane_dist[k >> 2]), 16)
                    + vs * smul_round(up[i], longint'(hgt[k >> 2]), 16)
                    + hs * smul_round(right[i], longint'(wid[k >> 2]), 16);
                case (i)
                    0: c.cx = clamp_q16(v);
                    1: c.cy = clamp_q16(v);
                    default: c.cz = clamp_q16(v);
                endcase
            end
            corners_due.insert(corners_due.size(), c);
        end
    endfunction

    function automatic void add_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [15:0] pitch, logic [15:0] yaw);
        t_op op;
        op.kind = OP_CAMERA;
        op.reg_idx = vfc_pkg::CFG_FOV;
        op.reg_data = '0;
        op.px = x;
        op.py = y;
        op.pz = z;
        op.pitch = pitch;
        op.yaw = yaw;
        camera_ops.insert(camera_ops.size(), op);
    endfunction

    function automatic void add_setting(vfc_pkg::t_cfg_idx idx, logic [31:0] data);
        t_op op;
        op.kind = OP_CFG;
        op.reg_idx = idx;
        op.reg_data = data;
        op.px = '0;
        op.py = '0;
        op.pz = '0;
        op.pitch = '0;
        op.yaw = '0;
        camera_ops.insert(camera_ops.size(), op);
    endfunction

    function automatic void add_drain();
        t_op op;
        op.kind = OP_DRAIN;
        op.reg_idx = vfc_pkg::CFG_FOV;
        op.reg_data = '0;
        op.px = '0;
        op.py = '0;
        op.pz = '0;
        op.pitch = '0;
        op.yaw = '0;
        camera_ops.insert(camera_ops.size(), op);
    endfunction

    // Positions are either full range, which mostly saturates, or small
    // enough that the frustum offsets actually show up in the corners.
    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
    endfunction

    // Pitch is steered toward the straight up and straight down steps now
    // and then, where the right vector is undefined.
    function automatic logic [15:0] rand_pitch();
        case ($urandom_range(0, 5))
            0: return 16'h4000 | 16'($urandom_range(0, 63));
            1: return 16'hC000 | 16'($urandom_range(0, 63));
            default: return 16'($urandom);
        endcase
    endfunction

    // Camera driver: beats change on the falling edge. A new beat is only
    // loaded once the previous one has been taken.
    always @(negedge i_clk) begin
        logic nxt_valid;
        logic nxt_we;
        t_op  op;
        nxt_valid = i_valid && !camera_taken;
        nxt_we = 1'b0;
        if (i_rst_n && !nxt_valid && camera_ops.size() != 0) begin
            op = camera_ops[0];
            case (op.kind)
                OP_CAMERA: begin
                    if (calm || $urandom_range(0, 99) >= 34) begin
                        void'(camera_ops.pop_front());
                        i_pos_x <= op.px;
                        i_pos_y <= op.py;
                        i_pos_z <= op.pz;
                        i_pitch_angle <= op.pitch;
                        i_yaw_angle <= op.yaw;
                        nxt_valid = 1'b1;
                    end
                end
                OP_CFG: begin
                    // Settings only move once the block has gone quiet.
                    if (corners_due.size() == 0 && quiet_cycles >= 20) begin
                        void'(camera_ops.pop_front());
                        i_cfg_index <= op.reg_idx;
                        i_cfg_data <= op.reg_data;
                        nxt_we = 1'b1;
                    end
                end
                default: begin
                    if (corners_due.size() == 0) void'(camera_ops.pop_front());
                end
            endcase
        end
        i_valid <= nxt_valid;
        i_cfg_we <= nxt_we;
        i_ready <= i_rst_n && (calm || $urandom_range(0, 99) >= 34);
    end

    // Monitor: samples both channels at the rising edge.
    always @(posedge i_clk) begin
        t_corner exp_c;
        camera_taken <= i_valid && o_ready;
        if (i_cfg_we) begin
            case (vfc_pkg::t_cfg_idx'(i_cfg_index))
                vfc_pkg::CFG_FOV:    fov_q <= i_cfg_data[14:0];
                vfc_pkg::CFG_NEAR:   near_q <= i_cfg_data;
                vfc_pkg::CFG_FAR:    far_q <= i_cfg_data;
                vfc_pkg::CFG_ASPECT: aspect_q <= i_cfg_data[15:0];
                default: ;
            endcase
        end
        if (i_valid && o_ready) begin
            predict_corners('{OP_CAMERA, vfc_pkg::CFG_FOV, 32'd0, i_pos_x, i_pos_y, i_pos_z,
                              i_pitch_angle, i_yaw_angle});
        end
        if (o_valid && i_ready) begin
            if (corners_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected corner beat: index %0d x %h y %h z %h",
                             o_corner_index, o_corner_x, o_corner_y, o_corner_z);
            end else begin
                exp_c = corners_due.pop_front();
                if (o_corner_index !== exp_c.index || o_corner_x !== exp_c.cx ||
                    o_corner_y !== exp_c.cy || o_corner_z !== exp_c.cz ||
                    o_degenerate !== exp_c.degen || o_last_corner !== exp_c.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("corner mismatch: expected idx %0d x %h y %h z %h dg %b last %b",
                                 exp_c.index, exp_c.cx, exp_c.cy, exp_c.cz,
                                 exp_c.degen, exp_c.last);
                        $display("                 actual   idx %0d x %h y %h z %h dg %b last %b",
                                 o_corner_index, o_corner_x, o_corner_y, o_corner_z,
                                 o_degenerate, o_last_corner);
                    end
                end
            end
        end
        if ((o_valid && i_ready) || corners_due.size() != 0) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: any cycle without a beat or a register write counts.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WD_LIMIT) begin
            $display("view_frustum_corners_unit test failed");
            $finish;
        end
    end

    initial begin
        int ops_total;
        build_sine_quadrant();

        // Directed part under the reset settings: the quadrant angles,
        // both degenerate pitches and the extremes of the position.
        add_camera(32'd0, 32'd0, 32'd0, 16'h0000, 16'h0000);
        add_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 16'h4000);
        add_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000);
        add_camera(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 16'h4000, 16'hC000);
        add_camera(32'd0, 32'd0, 32'd0, 16'h403F, 16'hFFFF);
        add_camera(32'd0, 32'd0, 32'd0, 16'hC000, 16'h2000);
        add_camera(32'd5, 32'hFFFF_FFFB, 32'd0, 16'hFFFF, 16'h1234);
        add_camera(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 16'h3FFF, 16'hBFFF);
        add_drain();

        // Extremes of every register, then random phases.
        add_setting(vfc_pkg::CFG_FOV, 32'd32767);
        add_setting(vfc_pkg::CFG_NEAR, 32'hFFFF_FFFF);
        add_setting(vfc_pkg::CFG_FAR, 32'hFFFF_FFFF);
        add_setting(vfc_pkg::CFG_ASPECT, 32'd65535);
        add_camera(32'd0, 32'd0, 32'd0, 16'h0000, 16'h0000);
        add_camera(32'd0, 32'd0, 32'd0, 16'h2000, 16'h6000);
        add_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'h4000, 16'h0000);
        add_setting(vfc_pkg::CFG_FOV, 32'hFFFF_8001);
        add_setting(vfc_pkg::CFG_NEAR, 32'd1);
        add_setting(vfc_pkg::CFG_FAR, 32'd1);
        add_setting(vfc_pkg::CFG_ASPECT, 32'd1);
        add_camera(32'd0, 32'd0, 32'd0, 16'h1000, 16'h7000);
        add_camera(32'h0000_8000, 32'd0, 32'hFFFF_8000, 16'hE000, 16'hA000);
        add_setting(vfc_pkg::CFG_FOV, 32'd0);
        add_setting(vfc_pkg::CFG_ASPECT, 32'd0);
        add_camera(32'd0, 32'd0, 32'd0, 16'h1000, 16'h7000);

        for (int ph = 0; ph < 6; ph++) begin
            add_setting(vfc_pkg::CFG_FOV, (ph == 5) ? 32'd8192 : $urandom);
            add_setting(vfc_pkg::CFG_NEAR,
                        (ph % 2 == 0) ? $urandom_range(1, 32'h0004_0000) : $urandom);
            add_setting(vfc_pkg::CFG_FAR,
                        (ph % 2 == 0) ? $urandom_range(1, 32'h0100_0000) : $urandom);
            add_setting(vfc_pkg::CFG_ASPECT, $urandom_range(0, 65535));
            for (int n = 0; n < 35; n++) begin
                if (n == 17) add_drain();
                add_camera(rand_pos(), rand_pos(), rand_pos(), rand_pitch(), 16'($urandom));
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A stretch late in the run goes without any idling.
        ops_total = camera_ops.size();
        while (camera_ops.size() > ops_total / 3) @(posedge i_clk);
        calm = 1'b1;
        while (camera_ops.size() > ops_total / 6) @(posedge i_clk);
        calm = 1'b0;

        while (camera_ops.size() != 0 || i_valid || corners_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && corners_due.size() == 0) begin
            $display("view_frustum_corners_unit test passed");
        end else begin
            $display("view_frustum_corners_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
